### rtl/ntse_pkg.sv
package ntse_pkg;

  localparam int MAX_SENTENCE_DEF = 128;
  localparam int CAPTURE_CHARS    = 6;
  localparam int TEXT_CHARS       = 6;
  localparam int TIME_START       = 6;
  localparam int TYPE_FINAL_POS   = 4;

  localparam int SPEED_LIMIT_MAX =
    (CAPTURE_CHARS < TEXT_CHARS) ? CAPTURE_CHARS : TEXT_CHARS;

  localparam logic [3:0] SPEED_FIELD_RST = 4'd7;
  localparam logic [2:0] SPEED_DIGITS_RST = 3'd4;
  localparam logic [3:0] COMMA_MAX = 4'd15;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_G      = 8'h47;

  typedef enum logic [0:0] {
    REG_SPEED_FIELD  = 1'b0,
    REG_SPEED_DIGITS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TYPE_UNKNOWN = 2'd0,
    TYPE_RMC     = 2'd1,
    TYPE_VTG     = 2'd2,
    TYPE_OTHER   = 2'd3
  } sent_type_t;

  typedef enum logic [1:0] {
    KIND_TIME_OK    = 2'd0,
    KIND_TIME_NONE  = 2'd1,
    KIND_SPEED_OK   = 2'd2,
    KIND_SPEED_NONE = 2'd3
  } result_kind_t;

  typedef struct packed {
    result_kind_t           kind;
    logic [TEXT_CHARS-1:0][7:0] chars;
    logic [2:0]             length;
  } result_t;

endpackage

### rtl/nmea_time_speed_extractor_unit.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-------------------------------------
// in_      | input     | in_valid / in_stall  | in_rx_byte
// out_     | output    | out_valid / out_stall| out_result_kind, out_text_char0..5,
//          |           |                      | out_text_length
// cfg_     | input     | cfg_wr_en            | cfg_index, cfg_wdata
//
// One byte is accepted per cycle while in_stall is low; its result, if any, shows on out_ in the next cycle.
// All per-byte parsing is one level of compare and count logic into the result register.
// rst_n is synchronous and active low; it clears parser state and the output valid.
// in_stall is high only while a result is held in the output register under out_stall.
module nmea_time_speed_extractor_unit #(
  parameter int MAX_SENTENCE = ntse_pkg::MAX_SENTENCE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_text_char0,
  output logic [7:0] out_text_char1,
  output logic [7:0] out_text_char2,
  output logic [7:0] out_text_char3,
  output logic [7:0] out_text_char4,
  output logic [7:0] out_text_char5,
  output logic [2:0] out_text_length,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [3:0] cfg_wdata
);

  localparam int PosW = $clog2(MAX_SENTENCE);
  localparam int TC   = ntse_pkg::TEXT_CHARS;

  logic [3:0] speed_field_r;
  logic [2:0] speed_digits_r;

  logic                 inside_r, inside_nxt;
  logic [PosW-1:0]      pos_r, pos_nxt;
  ntse_pkg::sent_type_t type_r, type_nxt;
  logic [3:0]           comma_r, comma_nxt;
  logic [TC-1:0][7:0]   store_r, store_nxt;
  logic [2:0]           cap_r, cap_nxt;
  logic                 done_r, done_nxt;

  ntse_pkg::result_t    res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 emit;

  logic in_fire, out_fire;
  logic [3:0] field_eff;
  logic [2:0] limit;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;

  assign field_eff = (speed_field_r == 4'd0) ? 4'd1 : speed_field_r;
  assign limit = (speed_digits_r == 3'd0) ? 3'd1 :
                 (speed_digits_r > 3'(ntse_pkg::SPEED_LIMIT_MAX)) ?
                 3'(ntse_pkg::SPEED_LIMIT_MAX) : speed_digits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_field_r  <= ntse_pkg::SPEED_FIELD_RST;
      speed_digits_r <= ntse_pkg::SPEED_DIGITS_RST;
    end else if (cfg_wr_en) begin
      unique case (ntse_pkg::cfg_reg_t'(cfg_index))
        ntse_pkg::REG_SPEED_FIELD:  speed_field_r  <= cfg_wdata;
        ntse_pkg::REG_SPEED_DIGITS: speed_digits_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [7:0]           c;
    ntse_pkg::sent_type_t t;
    logic [7:0]           want;
    logic                 in_field;
    logic [2:0]           cc0;
    logic [2:0]           len;
    ntse_pkg::result_kind_t kind;

    c          = in_rx_byte;
    t          = type_r;
    want       = 8'd0;
    in_field   = 1'b0;
    cc0        = 3'd0;
    len        = 3'd0;
    kind       = ntse_pkg::KIND_TIME_OK;
    emit       = 1'b0;
    inside_nxt = inside_r;
    pos_nxt    = pos_r;
    type_nxt   = type_r;
    comma_nxt  = comma_r;
    store_nxt  = store_r;
    cap_nxt    = cap_r;
    done_nxt   = done_r;

    if (c == ntse_pkg::CH_DOLLAR) begin
      inside_nxt = 1'b1;
      pos_nxt    = '0;
      type_nxt   = ntse_pkg::TYPE_UNKNOWN;
      comma_nxt  = 4'd0;
      cap_nxt    = 3'd0;
      done_nxt   = 1'b0;
    end else if (inside_r) begin
      if (pos_r == PosW'(2)) begin
        if (c == ntse_pkg::CH_R)      t = ntse_pkg::TYPE_RMC;
        else if (c == ntse_pkg::CH_V) t = ntse_pkg::TYPE_VTG;
        else                          t = ntse_pkg::TYPE_OTHER;
      end else if (pos_r == PosW'(3) || pos_r == PosW'(4)) begin
        if (type_r == ntse_pkg::TYPE_RMC) begin
          want = (pos_r == PosW'(3)) ? ntse_pkg::CH_M : ntse_pkg::CH_C;
          if (c != want) t = ntse_pkg::TYPE_OTHER;
        end else if (type_r == ntse_pkg::TYPE_VTG) begin
          want = (pos_r == PosW'(3)) ? ntse_pkg::CH_T : ntse_pkg::CH_G;
          if (c != want) t = ntse_pkg::TYPE_OTHER;
        end
      end
      type_nxt = t;

      in_field = !done_r && (comma_r == field_eff) &&
                 (t == ntse_pkg::TYPE_UNKNOWN || t == ntse_pkg::TYPE_VTG);

      if (t == ntse_pkg::TYPE_RMC && pos_r >= PosW'(ntse_pkg::TIME_START) && !done_r) begin
        if (pos_r == PosW'(ntse_pkg::TIME_START) && c == ntse_pkg::CH_COMMA) begin
          done_nxt = 1'b1;
          cap_nxt  = 3'd0;
          emit     = 1'b1;
          kind     = ntse_pkg::KIND_TIME_NONE;
          len      = 3'd0;
        end else begin
          cc0 = (pos_r == PosW'(ntse_pkg::TIME_START)) ? 3'd0 : cap_r;
          cap_nxt = cc0;
          if (cc0 < 3'(TC)) begin
            store_nxt[cc0] = c;
            cap_nxt        = cc0 + 3'd1;
          end
          if (cap_nxt >= 3'(TC)) begin
            done_nxt = 1'b1;
            emit     = 1'b1;
            kind     = ntse_pkg::KIND_TIME_OK;
            len      = 3'(TC);
          end
        end
      end else if (c == ntse_pkg::CH_COMMA) begin
        if (in_field) begin
          done_nxt = 1'b1;
          if (t == ntse_pkg::TYPE_VTG && pos_r > PosW'(ntse_pkg::TYPE_FINAL_POS)) begin
            emit = 1'b1;
            kind = (cap_r == 3'd0) ? ntse_pkg::KIND_SPEED_NONE : ntse_pkg::KIND_SPEED_OK;
            len  = cap_r;
          end
        end
        if (comma_r < ntse_pkg::COMMA_MAX) comma_nxt = comma_r + 4'd1;
      end else if (in_field && cap_r < limit) begin
        store_nxt[cap_r] = c;
        cap_nxt          = cap_r + 3'd1;
      end

      pos_nxt = pos_r + PosW'(1);
      if (pos_r == PosW'(MAX_SENTENCE - 1)) inside_nxt = 1'b0;
    end

    res_nxt.kind   = kind;
    res_nxt.length = len;
    for (int i = 0; i < TC; i++) begin
      res_nxt.chars[i] = (3'(i) < len) ? store_nxt[i] : 8'd0;
    end

    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    if (in_fire && emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r    <= 1'b0;
      pos_r       <= '0;
      type_r      <= ntse_pkg::TYPE_UNKNOWN;
      comma_r     <= 4'd0;
      cap_r       <= 3'd0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        inside_r <= inside_nxt;
        pos_r    <= pos_nxt;
        type_r   <= type_nxt;
        comma_r  <= comma_nxt;
        cap_r    <= cap_nxt;
        done_r   <= done_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      store_r <= store_nxt;
      if (emit) res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = res_r.kind;
  assign out_text_char0  = res_r.chars[0];
  assign out_text_char1  = res_r.chars[1];
  assign out_text_char2  = res_r.chars[2];
  assign out_text_char3  = res_r.chars[3];
  assign out_text_char4  = res_r.chars[4];
  assign out_text_char5  = res_r.chars[5];
  assign out_text_length = res_r.length;

endmodule

### rtl/ntse_checker.sv
module ntse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_result_kind,
  input logic [7:0] out_text_char5,
  input logic [2:0] out_text_length
);

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_kind) &&
    $stable(out_text_length))
    else $error("stalled result changed or dropped");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_missing_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == ntse_pkg::KIND_TIME_NONE ||
                  out_result_kind == ntse_pkg::KIND_SPEED_NONE)
    |-> out_text_length == 3'd0 && out_text_char5 == 8'd0)
    else $error("missing result carries text");

  a_length_by_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_kind == ntse_pkg::KIND_TIME_OK && out_text_length == 3'd6) ||
                  (out_result_kind == ntse_pkg::KIND_SPEED_OK && out_text_length != 3'd0 &&
                   out_text_length <= 3'd6) ||
                  out_result_kind == ntse_pkg::KIND_TIME_NONE ||
                  out_result_kind == ntse_pkg::KIND_SPEED_NONE)
    else $error("text length does not fit result kind");

endmodule

bind nmea_time_speed_extractor_unit ntse_checker u_ntse_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_result_kind(out_result_kind),
  .out_text_char5 (out_text_char5),
  .out_text_length(out_text_length)
);

### tb/nmea_result_checker.sv
module nmea_result_checker #(
  parameter int MAX_SENTENCE = ntse_pkg::MAX_SENTENCE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_result_kind,
  input  logic [7:0] out_text_char0,
  input  logic [7:0] out_text_char1,
  input  logic [7:0] out_text_char2,
  input  logic [7:0] out_text_char3,
  input  logic [7:0] out_text_char4,
  input  logic [7:0] out_text_char5,
  input  logic [2:0] out_text_length,
  input  logic       cfg_wr_en,
  input  logic       cfg_index,
  input  logic [3:0] cfg_wdata,
  output int         fail_count,
  output int         open_results
);

  logic [3:0]           field_sel;
  logic [2:0]           digit_sel;
  bit                   in_frame;
  int unsigned          frame_pos;
  ntse_pkg::sent_type_t frame_type;
  logic [3:0]           comma_seen;
  logic [7:0]           captured [ntse_pkg::TEXT_CHARS];
  int unsigned          captured_len;
  bit                   field_closed;
  ntse_pkg::result_t    expected_fixes [$];
  int                   fail_tally = 0;
  int                   fix_backlog = 0;

  assign fail_count   = fail_tally;
  assign open_results = fix_backlog;

  function automatic void open_frame();
    in_frame = 1'b1;
    frame_pos = 0;
    frame_type = ntse_pkg::TYPE_UNKNOWN;
    comma_seen = '0;
    for (int i = 0; i < ntse_pkg::TEXT_CHARS; i++) captured[i] = 8'h00;
    captured_len = 0;
    field_closed = 1'b0;
  endfunction

  function automatic ntse_pkg::result_t make_fix(input ntse_pkg::result_kind_t kind,
                                                 input int unsigned len);
    ntse_pkg::result_t r;
    r = '0;
    r.kind = kind;
    for (int i = 0; i < ntse_pkg::TEXT_CHARS; i++)
      r.chars[i] = (i < len) ? captured[i] : 8'h00;
    r.length = len[2:0];
    return r;
  endfunction

  function automatic bit decode_char(input int unsigned p, input logic [7:0] c,
                                     output ntse_pkg::result_t fix);
    int unsigned wanted_field;
    int unsigned digit_cap;
    logic [7:0]  want;
    bit          speed_open;
    bit          emitted;
    fix = '0;
    emitted = 1'b0;
    wanted_field = (field_sel == 0) ? 1 : field_sel;
    digit_cap = (digit_sel == 0) ? 1 : digit_sel;
    if (digit_cap > ntse_pkg::SPEED_LIMIT_MAX) digit_cap = ntse_pkg::SPEED_LIMIT_MAX;

    if (p == 2) begin
      if (c == ntse_pkg::CH_R) frame_type = ntse_pkg::TYPE_RMC;
      else if (c == ntse_pkg::CH_V) frame_type = ntse_pkg::TYPE_VTG;
      else frame_type = ntse_pkg::TYPE_OTHER;
    end else if ((p == 3 || p == 4) &&
                 (frame_type == ntse_pkg::TYPE_RMC || frame_type == ntse_pkg::TYPE_VTG)) begin
      if (frame_type == ntse_pkg::TYPE_RMC) want = (p == 3) ? ntse_pkg::CH_M : ntse_pkg::CH_C;
      else want = (p == 3) ? ntse_pkg::CH_T : ntse_pkg::CH_G;
      if (c != want) frame_type = ntse_pkg::TYPE_OTHER;
    end

    if (frame_type == ntse_pkg::TYPE_RMC && p >= ntse_pkg::TIME_START && !field_closed) begin
      if (p == ntse_pkg::TIME_START && c == ntse_pkg::CH_COMMA) begin
        field_closed = 1'b1;
        captured_len = 0;
        fix = make_fix(ntse_pkg::KIND_TIME_NONE, 0);
        return 1'b1;
      end
      if (p == ntse_pkg::TIME_START) captured_len = 0;
      if (captured_len < ntse_pkg::TEXT_CHARS) begin
        captured[captured_len] = c;
        captured_len++;
      end
      if (captured_len >= ntse_pkg::TEXT_CHARS) begin
        field_closed = 1'b1;
        fix = make_fix(ntse_pkg::KIND_TIME_OK, ntse_pkg::TEXT_CHARS);
        return 1'b1;
      end
      return 1'b0;
    end

    speed_open = !field_closed && comma_seen == wanted_field &&
                 (frame_type == ntse_pkg::TYPE_UNKNOWN || frame_type == ntse_pkg::TYPE_VTG);
    if (c == ntse_pkg::CH_COMMA) begin
      if (speed_open) begin
        field_closed = 1'b1;
        if (frame_type == ntse_pkg::TYPE_VTG && p > ntse_pkg::TYPE_FINAL_POS) begin
          fix = (captured_len == 0) ? make_fix(ntse_pkg::KIND_SPEED_NONE, 0)
                                    : make_fix(ntse_pkg::KIND_SPEED_OK, captured_len);
          emitted = 1'b1;
        end
      end
      if (comma_seen < ntse_pkg::COMMA_MAX) comma_seen++;
      return emitted;
    end

    if (speed_open && captured_len < digit_cap) begin
      captured[captured_len] = c;
      captured_len++;
    end
    return 1'b0;
  endfunction

  function automatic bit take_byte(input logic [7:0] c, output ntse_pkg::result_t fix);
    bit got;
    fix = '0;
    got = 1'b0;
    if (c == ntse_pkg::CH_DOLLAR) begin
      open_frame();
    end else if (in_frame) begin
      got = decode_char(frame_pos, c, fix);
      frame_pos++;
      if (frame_pos >= MAX_SENTENCE) in_frame = 1'b0;
    end
    return got;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    ntse_pkg::result_t fix;
    ntse_pkg::result_t seen;
    if (!rst_n) begin
      field_sel = ntse_pkg::SPEED_FIELD_RST;
      digit_sel = ntse_pkg::SPEED_DIGITS_RST;
      open_frame();
      in_frame = 1'b0;
      expected_fixes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen.kind = ntse_pkg::result_kind_t'(out_result_kind);
        seen.chars[0] = out_text_char0;
        seen.chars[1] = out_text_char1;
        seen.chars[2] = out_text_char2;
        seen.chars[3] = out_text_char3;
        seen.chars[4] = out_text_char4;
        seen.chars[5] = out_text_char5;
        seen.length = out_text_length;
        if (expected_fixes.size() == 0) begin
          $display("%0t: result expected none actual kind %0d length %0d",
                   $time, out_result_kind, out_text_length);
          fail_tally++;
        end else begin
          fix = expected_fixes.pop_front();
          compare_field("result_kind", fix.kind, seen.kind);
          for (int i = 0; i < ntse_pkg::TEXT_CHARS; i++)
            compare_field($sformatf("text_char%0d", i), fix.chars[i], seen.chars[i]);
          compare_field("text_length", fix.length, seen.length);
        end
      end
      if (in_valid && !in_stall) begin
        if (take_byte(in_rx_byte, fix)) expected_fixes.push_back(fix);
      end
      if (cfg_wr_en) begin
        if (cfg_index == ntse_pkg::REG_SPEED_FIELD) field_sel = cfg_wdata;
        else digit_sel = cfg_wdata[2:0];
      end
    end
    fix_backlog = expected_fixes.size();
  end

endmodule

### tb/tb_nmea_time_speed_extractor_unit.sv
module tb_nmea_time_speed_extractor_unit;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 250;
  localparam int PHASE_BYTES = 100;
  localparam int PHASE_RESULTS = 8;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_result_kind;
  logic [7:0] out_text_char0;
  logic [7:0] out_text_char1;
  logic [7:0] out_text_char2;
  logic [7:0] out_text_char3;
  logic [7:0] out_text_char4;
  logic [7:0] out_text_char5;
  logic [2:0] out_text_length;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_index = 1'b0;
  logic [3:0] cfg_wdata = 4'h0;

  int         fail_count;
  int         open_results;
  int         cycles = 0;
  int         results_taken = 0;
  int         bytes_sent = 0;
  int         burst_left = 0;
  int         hold_asks = 0;
  logic [3:0] field_now = ntse_pkg::SPEED_FIELD_RST;
  logic [7:0] frame [$];

  nmea_time_speed_extractor_unit u_top (.*);

  nmea_result_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (out_valid && !out_stall) results_taken++;
    if (cycles > CYCLE_LIMIT) begin
      $display("nmea_time_speed_extractor_unit verification failed");
      $finish;
    end
  end

  initial begin
    stall_mode_t stall_mode;
    int          stretch_left;
    int          hold_left;
    int          hold_served;
    stall_mode = STALL_NONE;
    stretch_left = 0;
    hold_left = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_served < hold_asks) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        if (stretch_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          stretch_left = $urandom_range(10, 120);
        end
        stretch_left--;
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default:     out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 200);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 6);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i]);
    frame.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (open_results != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [3:0] field_val, input logic [3:0] digit_val);
    cfg_wr_en <= 1'b1;
    cfg_index <= ntse_pkg::REG_SPEED_FIELD;
    cfg_wdata <= field_val;
    @(posedge clk);
    cfg_index <= ntse_pkg::REG_SPEED_DIGITS;
    cfg_wdata <= digit_val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    field_now = field_val;
  endtask

  function automatic logic [7:0] field_char();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: b = CH_ZERO + 8'($urandom_range(0, 9));
      5:             b = CH_DOT;
      6, 7:          b = CH_UPPER_A + 8'($urandom_range(0, 25));
      default: begin
        do b = 8'($urandom_range(0, 255));
        while (b == ntse_pkg::CH_DOLLAR || b == ntse_pkg::CH_COMMA);
      end
    endcase
    return b;
  endfunction

  function automatic logic [7:0] speed_char();
    case ($urandom_range(0, 9))
      0:       return CH_DOT;
      1:       return field_char();
      default: return CH_ZERO + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
  endfunction

  function automatic void push_header(input string kind);
    frame.push_back(ntse_pkg::CH_DOLLAR);
    for (int i = 0; i < 2; i++) begin
      case ($urandom_range(0, 9))
        0:       frame.push_back(ntse_pkg::CH_COMMA);
        1:       frame.push_back(field_char());
        default: frame.push_back((i == 0) ? ntse_pkg::CH_G : 8'h50);
      endcase
    end
    push_text(kind);
  endfunction

  function automatic void push_fields(input int count, input int max_len);
    repeat (count) begin
      frame.push_back(ntse_pkg::CH_COMMA);
      repeat ($urandom_range(0, max_len)) frame.push_back(field_char());
    end
  endfunction

  function automatic void build_rmc();
    push_header("RMC");
    frame.push_back(ntse_pkg::CH_COMMA);
    if ($urandom_range(0, 5) == 0) begin
      frame.push_back(ntse_pkg::CH_COMMA);
    end else begin
      repeat (6) begin
        case ($urandom_range(0, 9))
          0:       frame.push_back(ntse_pkg::CH_COMMA);
          1:       frame.push_back(field_char());
          default: frame.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        endcase
      end
    end
    push_fields($urandom_range(0, 4), 4);
  endfunction

  function automatic void build_vtg();
    int eff;
    int n;
    eff = (field_now == 0) ? 1 : field_now;
    push_header("VTG");
    case ($urandom_range(0, 7))
      0:       n = $urandom_range(0, eff);
      1:       n = 17;
      default: n = eff + $urandom_range(1, 3);
    endcase
    repeat (n) begin
      frame.push_back(ntse_pkg::CH_COMMA);
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) frame.push_back(speed_char());
    end
  endfunction

  function automatic void build_other();
    case ($urandom_range(0, 7))
      0: push_header("RMX");
      1: push_header("RTC");
      2: push_header("VMG");
      3: push_header("VTC");
      4: push_header("RMG");
      5: push_header("XTG");
      6: push_header("GGA");
      default: begin
        push_header("");
        repeat (3) frame.push_back(field_char());
      end
    endcase
    push_fields($urandom_range(0, 8), 5);
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_long();
    int stop_at;
    stop_at = $urandom_range(125, 140);
    push_header(($urandom_range(0, 1) == 0) ? "VTG" : "RMC");
    while (frame.size() < stop_at)
      frame.push_back(($urandom_range(0, 4) == 0) ? ntse_pkg::CH_COMMA : field_char());
  endfunction

  task automatic run_phase();
    int sent_start;
    int res_start;
    int pick;
    int cut;
    sent_start = bytes_sent;
    res_start = results_taken;
    while (bytes_sent - sent_start < PHASE_BYTES ||
           results_taken - res_start < PHASE_RESULTS) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) build_rmc();
      else if (pick < 76) build_vtg();
      else if (pick < 86) build_other();
      else if (pick < 96) build_noise();
      else build_long();
      if (frame.size() > 1 && $urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, frame.size() - 1);
        while (frame.size() > cut) void'(frame.pop_back());
      end
      send_frame();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    apply_settings(4'd1, 4'd7);
    send_byte(8'hFF);
    send_byte(8'h00);
    push_text("$GPRMC,,");
    push_text("$GPVTG,1234567,");
    send_frame();
    run_phase();

    drain();
    apply_settings(ntse_pkg::SPEED_FIELD_RST, 4'(ntse_pkg::SPEED_DIGITS_RST));
    hold_asks++;
    run_phase();

    drain();
    apply_settings(4'd15, 4'd6);
    run_phase();

    drain();
    apply_settings(4'd0, 4'd0);
    run_phase();

    drain();
    apply_settings(4'd3, 4'hF);
    run_phase();

    drain();
    apply_settings(4'($urandom_range(1, 15)), 4'($urandom_range(0, 15)));
    hold_asks++;
    run_phase();

    drain();
    apply_settings(4'd2, 4'b1011);
    run_phase();

    drain();
    repeat (5) @(posedge clk);
    if (fail_count == 0 && open_results == 0) begin
      $display("nmea_time_speed_extractor_unit verification clean");
    end else begin
      $display("nmea_time_speed_extractor_unit verification failed");
    end
    $finish;
  end

endmodule

### nmea_time_speed_extractor_unit.f
rtl/ntse_pkg.sv
rtl/nmea_time_speed_extractor_unit.sv
rtl/ntse_checker.sv
tb/nmea_result_checker.sv
tb/tb_nmea_time_speed_extractor_unit.sv
